// ----- hw/rtl/msva_pkg.sv -----
// msva_pkg: shared types and codes for the modular slot vector alu
// no dependencies; imported by every module of the block
package msva_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_SQR = 3'd3,
    CMD_NEG = 3'd4,
    CMD_ROT = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVF_ERR    = 3'd1,
    ST_UNF_ERR    = 3'd2,
    ST_RANGE_WARN = 3'd3,
    ST_OVF_WARN   = 3'd4,
    ST_UNF_WARN   = 3'd5,
    ST_INT64_OVF  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_SIGNED  = 2'd1,
    REG_DELAYED = 2'd2,
    REG_WARN    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_MUL,
    S_RED,
    S_DIV,
    S_HOLD,
    S_RD,
    S_WR
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] steps;
    logic        last;
  } slot_item_t;

  typedef struct packed {
    logic [61:0] modulus;
    logic        signed_mode;
    logic        delayed;
    logic        warn;
  } cfg_t;

endpackage

// ----- hw/rtl/modular_slot_vector_alu.sv -----
// modular_slot_vector_alu: packed-slot modular arithmetic with vector rotation
// result path, item accept to result accept: execute, then the multiplier for mul/square,
// then reduction, with the bit-serial remainder when unsigned reduction needs it, then the
// output register; a completing rotate sets its shift, then reads and gives out each slot in turn
// one item in execution at a time; the next item is taken once the last is done
// reset: synchronous, active high; clears control, config to its defaults
module modular_slot_vector_alu #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  input  logic signed [31:0] rotate_steps,
  input  logic               last_slot,
  // result item channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] result_value,
  output logic [2:0]         status,
  output logic               last_result,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import msva_pkg::*;

  // configuration registers
  logic [61:0] modulus;
  logic        signed_mode;
  logic        delayed_reduction;
  logic        overflow_warnings;
  cfg_t        cfg;

  // queue between front and back
  logic        q_valid;
  logic        q_ready;
  slot_item_t  q_item;
  logic [63:0] out_value;

  // writes are always taken; the user must write only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus           <= 62'd65537;
      signed_mode       <= 1'b0;
      delayed_reduction <= 1'b0;
      overflow_warnings <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_MODULUS: modulus           <= cfg_data[61:0];
        REG_SIGNED:  signed_mode       <= cfg_data[0];
        REG_DELAYED: delayed_reduction <= cfg_data[0];
        REG_WARN:    overflow_warnings <= cfg_data[0];
        default:     modulus           <= modulus;
      endcase
    end
  end

  // a zero modulus behaves as one
  assign cfg.modulus     = (modulus == 62'd0) ? 62'd1 : modulus;
  assign cfg.signed_mode = signed_mode;
  assign cfg.delayed     = delayed_reduction;
  assign cfg.warn        = overflow_warnings;

  // front: takes items, drops unused command codes, queues the rest
  msva_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .rotate_steps (rotate_steps),
    .last_slot    (last_slot),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  // back: arithmetic, reduction, rotation buffer and the output register
  msva_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (status),
    .out_last   (last_result)
  );

  assign result_value = out_value;

endmodule

// ----- hw/rtl/msva_front.sv -----
// msva_front: input acceptance, command classification and a two-entry queue
// depends on msva_pkg
module msva_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             command,
  input  logic signed [63:0]     operand_a,
  input  logic signed [63:0]     operand_b,
  input  logic signed [31:0]     rotate_steps,
  input  logic                   last_slot,
  output logic                   q_valid,
  input  logic                   q_ready,
  output msva_pkg::slot_item_t   q_item
);
  import msva_pkg::*;

  slot_item_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       known;

  assign in_ready = (count != 2'd2);
  // unused codes are dropped here and never reach the back end
  assign known    = (command <= 3'(CMD_ROT));
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].cmd   <= cmd_t'(command);
      q[wp].a     <= operand_a;
      q[wp].b     <= operand_b;
      q[wp].steps <= rotate_steps;
      q[wp].last  <= last_slot;
    end
  end

endmodule

// ----- hw/rtl/msva_mul.sv -----
// msva_mul: 64x64 signed multiply with int64 overflow flag, one 32x32 product a cycle
// depends on msva_pkg
module msva_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product,
  output logic        ovf
);
  import msva_pkg::*;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  pa;
  logic [31:0]  pb;

  assign pa = cnt[1] ? ma[63:32] : ma[31:0];
  assign pb = cnt[0] ? mb[63:32] : mb[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
      cnt    <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= 3'd0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        pp_vld <= (cnt < 3'd4);
        cnt    <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[63] ? (64'd0 - a) : a;
      mb  <= b[63] ? (64'd0 - b) : b;
      neg <= a[63] ^ b[63];
      acc <= 128'd0;
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp    <= {32'd0, pa} * {32'd0, pb};
        pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      if (pp_vld) acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
    end
  end

  // magnitude limit is 2^63 for a negative product, 2^63-1 otherwise
  assign ovf     = neg ? ((acc[127:63] > 65'd1) || (acc[127:63] == 65'd1 && acc[62:0] != 63'd0))
                       : (acc[127:63] != 65'd0);
  assign product = neg ? (64'd0 - acc[63:0]) : acc[63:0];

endmodule

// ----- hw/rtl/msva_rem.sv -----
// msva_rem: bit-serial Euclidean remainder of a signed 64-bit value by a 62-bit divisor
// depends on msva_pkg
module msva_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [61:0] divisor,
  output logic        done,
  output logic [61:0] remainder
);
  import msva_pkg::*;

  logic [63:0] mag;
  logic [61:0] dv;
  logic [61:0] r;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [62:0] shifted;
  logic [62:0] diff;
  logic        ge;

  assign shifted = {r, mag[63]};
  assign ge      = (shifted >= {1'b0, dv});
  assign diff    = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= dividend[63] ? (64'd0 - dividend) : dividend;
      neg <= dividend[63];
      dv  <= divisor;
      r   <= 62'd0;
    end else if (busy) begin
      r   <= ge ? diff[61:0] : shifted[61:0];
      mag <= {mag[62:0], 1'b0};
    end
  end

  // negative dividend folds back into [0, divisor)
  assign remainder = (neg && r != 62'd0) ? (dv - r) : r;

endmodule

// ----- hw/rtl/msva_back.sv -----
// msva_back: sequencer that executes queued items, reduces results, runs rotations
// depends on msva_pkg, msva_mul, msva_rem
module msva_back #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  msva_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  msva_pkg::slot_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_value,
  output logic [2:0]           out_status,
  output logic                 out_last
);
  import msva_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FC_W  = $clog2(SLOTS + 1);
  // shift amount: reciprocal multiply of the biased step count, then a small fix-up
  localparam logic [32:0] RECIP = 33'((65'd1 << 32) / SLOTS);
  localparam int          OFS   = int'((64'd1 << 31) % SLOTS);
  localparam logic [7:0]  BIASC = 8'(SLOTS - OFS);
  localparam logic [7:0]  S8    = 8'(SLOTS);

  back_state_t st;
  back_state_t st_next;
  slot_item_t  cur;
  logic [63:0] x;
  logic        ok;
  logic [63:0] val;
  status_t     stat;
  logic [FC_W-1:0]  fill;
  logic [FC_W-1:0]  fill_inc;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] sh;
  logic [IDX_W:0]   addr_sum;
  logic [IDX_W-1:0] rd_addr;
  logic [63:0]      rd_q;
  logic [63:0]      mem [SLOTS];

  logic        out_free;
  logic        take;
  logic        mul_start;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        mul_ovf;
  logic        rem_start;
  logic        rem_done;
  logic [63:0] rem_x;
  logic [61:0] rem_m;
  logic [61:0] rem_r;
  logic        mem_we;
  logic        load_hold;
  logic        load_wr;
  logic        complete;
  logic        last_idx;

  // rotate amount modulo the slot count
  logic [31:0] steps_u;
  logic [64:0] rprod;
  logic [7:0]  sq;
  logic [7:0]  sq_mul;
  logic [7:0]  sr1;
  logic [7:0]  sr2;
  logic [7:0]  sr3;

  // element-wise raw results
  logic [63:0] sum;
  logic [63:0] dif;
  logic        add_ok;
  logic        sub_ok;
  logic        neg_ok;
  logic [63:0] exec_x;
  logic        exec_ok;
  logic        exec_mul;

  // reduction
  logic [61:0] m_half;
  logic [65:0] xs;
  logic [65:0] ms;
  logic [65:0] hs;
  logic        gt_half;
  logic        lt_half;
  logic        in_range;
  logic        red_div;
  logic [63:0] red_val;
  status_t     red_stat;

  assign out_free = !out_valid || out_ready;
  assign fill_inc = fill + FC_W'(1);
  assign complete = cur.last || (fill_inc >= FC_W'(SLOTS));
  assign last_idx = (idx == IDX_W'(SLOTS - 1));
  assign addr_sum = {1'b0, idx} + {1'b0, sh};
  assign rd_addr  = (addr_sum >= (IDX_W + 1)'(SLOTS)) ?
                    IDX_W'(addr_sum - (IDX_W + 1)'(SLOTS)) : addr_sum[IDX_W-1:0];

  // steps + 2^31 is non-negative; quotient estimate is exact or one low
  assign steps_u = cur.steps ^ 32'h80000000;
  assign rprod   = steps_u * RECIP;
  assign sq_mul  = 8'(sq * S8);
  // remainder plus slot count minus the bias residue stays below three slot counts
  assign sr1     = cur.steps[7:0] + BIASC - sq_mul;
  assign sr2     = (sr1 >= S8) ? sr1 - S8 : sr1;
  assign sr3     = (sr2 >= S8) ? sr2 - S8 : sr2;

  assign sum    = cur.a + cur.b;
  assign dif    = cur.a - cur.b;
  assign add_ok = !((cur.a[63] == cur.b[63]) && (sum[63] != cur.a[63]));
  assign sub_ok = !((cur.a[63] != cur.b[63]) && (dif[63] != cur.a[63]));
  assign neg_ok = (cur.a != {1'b1, 63'd0});

  always_comb begin
    exec_x   = sum;
    exec_ok  = add_ok;
    exec_mul = 1'b0;
    case (cur.cmd)
      CMD_ADD: begin
        exec_x  = sum;
        exec_ok = add_ok;
      end
      CMD_SUB: begin
        exec_x  = dif;
        exec_ok = sub_ok;
      end
      CMD_MUL, CMD_SQR: exec_mul = 1'b1;
      CMD_NEG: begin
        exec_x  = 64'd0 - cur.a;
        exec_ok = neg_ok;
      end
      default: exec_mul = 1'b0;
    endcase
  end

  assign m_half   = cfg.modulus >> 1;
  assign xs       = {{2{x[63]}}, x};
  assign ms       = {4'd0, cfg.modulus};
  assign hs       = {5'd0, m_half[60:0]};
  assign gt_half  = $signed(xs) > $signed(hs);
  assign lt_half  = $signed(xs + ms) < $signed(hs);
  assign in_range = !x[63] && ($signed(xs) < $signed(ms));

  always_comb begin
    red_val  = x;
    red_stat = ST_OK;
    red_div  = 1'b0;
    if (!ok) begin
      red_val  = 64'd0;
      red_stat = ST_INT64_OVF;
    end else if (!cfg.delayed && cfg.signed_mode) begin
      if (gt_half) begin
        red_val  = 64'd0;
        red_stat = ST_OVF_ERR;
      end else if (lt_half) begin
        red_val  = 64'd0;
        red_stat = ST_UNF_ERR;
      end
    end else if (!cfg.delayed) begin
      red_div = !in_range;
    end else if (cfg.warn && cfg.signed_mode) begin
      if (gt_half) red_stat = ST_OVF_WARN;
      else if (lt_half) red_stat = ST_UNF_WARN;
    end else if (cfg.warn) begin
      if (!in_range) red_stat = ST_RANGE_WARN;
    end
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: if (q_valid) st_next = S_EXEC;
      S_EXEC: begin
        if (cur.cmd == CMD_ROT) st_next = complete ? S_SHIFT : S_IDLE;
        else if (exec_mul) st_next = S_MUL;
        else st_next = S_RED;
      end
      S_SHIFT: st_next = S_RD;
      S_MUL:  if (mul_done) st_next = S_RED;
      S_RED:  st_next = red_div ? S_DIV : S_HOLD;
      S_DIV:  if (rem_done) st_next = S_HOLD;
      S_HOLD: if (out_free) st_next = S_IDLE;
      S_RD:   st_next = S_WR;
      S_WR:   if (out_free) st_next = last_idx ? S_IDLE : S_RD;
      default: st_next = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    take      = 1'b0;
    mul_start = 1'b0;
    rem_start = 1'b0;
    mem_we    = 1'b0;
    load_hold = 1'b0;
    load_wr   = 1'b0;
    rem_x     = x;
    rem_m     = cfg.modulus;
    case (st)
      S_IDLE: take = q_valid;
      S_EXEC: begin
        mul_start = exec_mul;
        mem_we    = (cur.cmd == CMD_ROT);
      end
      S_RED:  rem_start = red_div;
      S_HOLD: load_hold = out_free;
      S_WR:   load_wr = out_free;
      default: take = 1'b0;
    endcase
  end

  assign q_ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (mem_we) fill <= complete ? '0 : fill_inc;
      if (load_hold || load_wr) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= q_item;
    if (st == S_EXEC) begin
      x  <= exec_x;
      ok <= exec_ok;
      sq <= rprod[39:32];
    end
    if (st == S_SHIFT) begin
      sh  <= sr3[IDX_W-1:0];
      idx <= '0;
    end
    if (st == S_MUL && mul_done) begin
      x  <= mul_prod;
      ok <= !mul_ovf;
    end
    if (st == S_RED) begin
      val  <= red_val;
      stat <= red_stat;
    end
    if (st == S_DIV && rem_done) begin
      val  <= {2'd0, rem_r};
      stat <= ST_OK;
    end
    if (load_wr && !last_idx) idx <= idx + IDX_W'(1);
    if (load_hold) begin
      out_value  <= val;
      out_status <= stat;
      out_last   <= cur.last;
    end
    if (load_wr) begin
      out_value  <= rd_q;
      out_status <= ST_OK;
      out_last   <= last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[fill[IDX_W-1:0]] <= cur.a;
    rd_q <= mem[rd_addr];
  end

  msva_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (cur.a),
    .b       ((cur.cmd == CMD_SQR) ? cur.a : cur.b),
    .done    (mul_done),
    .product (mul_prod),
    .ovf     (mul_ovf)
  );

  msva_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_x),
    .divisor   (rem_m),
    .done      (rem_done),
    .remainder (rem_r)
  );

endmodule
